@@ design/mpq_pkg.sv @@
package mpq_pkg;

  localparam int CAPACITY  = 8;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int OCC_W     = 4;
  localparam int STATUS_W  = 2;
  localparam int STEP_W    = 4;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_INSERT,
    ACT_EMPTY,
    ACT_SCAN_START,
    ACT_SCAN,
    ACT_SHIFT_START,
    ACT_SHIFT,
    ACT_EXT_DONE,
    ACT_LOAD_OUT
  } act_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NEVER,
    COND_NO_INPUT,
    COND_OP_EXTRACT,
    COND_EMPTY,
    COND_PTR_MORE,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    logic              accept;
    act_t              act;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctl_t;

  localparam logic [STEP_W-1:0] STEP_IDLE        = 4'd0;
  localparam logic [STEP_W-1:0] STEP_DISPATCH    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_INSERT      = 4'd2;
  localparam logic [STEP_W-1:0] STEP_EXT_CHECK   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_SCAN_START  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SCAN        = 4'd5;
  localparam logic [STEP_W-1:0] STEP_SHIFT_START = 4'd6;
  localparam logic [STEP_W-1:0] STEP_SHIFT       = 4'd7;
  localparam logic [STEP_W-1:0] STEP_EXT_DONE    = 4'd8;
  localparam logic [STEP_W-1:0] STEP_OUT         = 4'd9;
  localparam logic [STEP_W-1:0] STEP_OUT_WAIT    = 4'd10;

  function automatic ctl_t microcode(input logic [STEP_W-1:0] step);
    ctl_t w;
    w = '{accept: 1'b0, act: ACT_NONE, cond: COND_ALWAYS, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE:        w = '{1'b1, ACT_NONE,        COND_NO_INPUT,   STEP_IDLE};
      STEP_DISPATCH:    w = '{1'b0, ACT_NONE,        COND_OP_EXTRACT, STEP_EXT_CHECK};
      STEP_INSERT:      w = '{1'b0, ACT_INSERT,      COND_ALWAYS,     STEP_OUT};
      STEP_EXT_CHECK:   w = '{1'b0, ACT_EMPTY,       COND_EMPTY,      STEP_OUT};
      STEP_SCAN_START:  w = '{1'b0, ACT_SCAN_START,  COND_NEVER,      STEP_IDLE};
      STEP_SCAN:        w = '{1'b0, ACT_SCAN,        COND_PTR_MORE,   STEP_SCAN};
      STEP_SHIFT_START: w = '{1'b0, ACT_SHIFT_START, COND_NEVER,      STEP_IDLE};
      STEP_SHIFT:       w = '{1'b0, ACT_SHIFT,       COND_PTR_MORE,   STEP_SHIFT};
      STEP_EXT_DONE:    w = '{1'b0, ACT_EXT_DONE,    COND_NEVER,      STEP_IDLE};
      STEP_OUT:         w = '{1'b0, ACT_LOAD_OUT,    COND_OUT_FREE,   STEP_IDLE};
      STEP_OUT_WAIT:    w = '{1'b0, ACT_NONE,        COND_ALWAYS,     STEP_OUT};
      default:          w = '{1'b0, ACT_NONE,        COND_ALWAYS,     STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ design/min_priority_queue_array_unit.sv @@
// Minimum-first priority queue over an unsorted table of CAPACITY signed words.
// Input channel (in_valid/in_ready): opcode 0 inserts insert_value at the end
// of the stored run, opcode 1 extracts the smallest stored value, earliest
// stored first on ties. Output channel (out_valid/out_ready): one word per
// input word with status (ok, overflow, underflow), min_value (zero unless an
// extract succeeded) and occupancy after the operation.
// A microcode sequencer steps through a small control table; the stored values
// are held in one RAM with a single write and a single registered read port.
// An insert, or an extract from an empty queue, steps through dispatch, one action step
// and the output step. An extract steps through dispatch, the empty check, a scan of
// every entry for the minimum, a shift of the entries above it down by one, the done
// step and the output step; the read port, used once per entry for the scan and again
// for the shift, makes the extract time grow with the occupancy.
// One word is in work at a time and in_ready is high only in the idle step, which
// begins as the result is loaded into the output register, so the next word can be
// accepted in the same cycle as out_valid rises.
// The output register lets a new word be accepted while a result waits.
// Reset (rst, synchronous) empties the queue and drops any pending result.
// When the receiver stalls, the result is held and the sequencer waits before
// loading the next one.
module min_priority_queue_array_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           opcode,
  input  logic signed [31:0]             insert_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mpq_pkg::STATUS_W-1:0]   status,
  output logic signed [31:0]             min_value,
  output logic [mpq_pkg::OCC_W-1:0]      occupancy
);

  import mpq_pkg::*;

  logic [STEP_W-1:0]        upc;
  logic [STEP_W-1:0]        upc_next;
  ctl_t                     ctl;
  logic                     cond_true;

  logic                     op;
  logic signed [DATA_W-1:0] val;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         ptr;
  logic                     pend;
  logic [IDX_W-1:0]         pend_idx;
  logic                     first;
  logic signed [DATA_W-1:0] min_val;
  logic [IDX_W-1:0]         min_pos;
  logic [STATUS_W-1:0]      res_status;
  logic signed [DATA_W-1:0] res_min;

  logic                     in_acc;
  logic                     out_free;
  logic                     ptr_more;
  logic                     full;
  logic                     empty;

  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic [IDX_W-1:0]         ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] rd_val;

  assign ctl      = microcode(upc);
  assign in_ready = ctl.accept;
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign ptr_more = ptr < count;
  assign full     = count == CNT_W'(CAPACITY);
  assign empty    = count == '0;
  assign rd_val   = $signed(ram_rdata);

  always_comb begin
    unique case (ctl.cond)
      COND_ALWAYS:     cond_true = 1'b1;
      COND_NEVER:      cond_true = 1'b0;
      COND_NO_INPUT:   cond_true = !in_acc;
      COND_OP_EXTRACT: cond_true = op == OP_EXTRACT;
      COND_EMPTY:      cond_true = empty;
      COND_PTR_MORE:   cond_true = ptr_more;
      COND_OUT_FREE:   cond_true = out_free;
      default:         cond_true = 1'b0;
    endcase
    upc_next = cond_true ? ctl.target : STEP_W'(upc + 1'b1);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[IDX_W-1:0];
    ram_wdata = val;
    ram_raddr = ptr[IDX_W-1:0];
    unique case (ctl.act)
      ACT_INSERT: begin
        ram_we = !full;
      end
      ACT_SCAN_START: begin
        ram_raddr = '0;
      end
      ACT_SHIFT: begin
        ram_we    = pend;
        ram_waddr = IDX_W'(pend_idx - 1'b1);
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  mpq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      upc   <= STEP_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      upc <= upc_next;
      if (in_acc) begin
        op  <= opcode;
        val <= insert_value;
      end
      unique case (ctl.act)
        ACT_INSERT: begin
          res_min <= '0;
          if (full) begin
            res_status <= STATUS_OVERFLOW;
          end else begin
            res_status <= STATUS_OK;
            count      <= CNT_W'(count + 1'b1);
          end
        end
        ACT_EMPTY: begin
          res_min    <= '0;
          res_status <= STATUS_UNDERFLOW;
        end
        ACT_SCAN_START: begin
          ptr      <= CNT_W'(1);
          pend     <= 1'b1;
          pend_idx <= '0;
          first    <= 1'b1;
        end
        ACT_SCAN: begin
          if (pend) begin
            first <= 1'b0;
            if (first || (rd_val < min_val)) begin
              min_val <= rd_val;
              min_pos <= pend_idx;
            end
          end
          if (ptr_more) begin
            ptr      <= CNT_W'(ptr + 1'b1);
            pend     <= 1'b1;
            pend_idx <= ptr[IDX_W-1:0];
          end else begin
            pend <= 1'b0;
          end
        end
        ACT_SHIFT_START: begin
          ptr  <= CNT_W'({1'b0, min_pos} + 1'b1);
          pend <= 1'b0;
        end
        ACT_SHIFT: begin
          if (ptr_more) begin
            ptr      <= CNT_W'(ptr + 1'b1);
            pend     <= 1'b1;
            pend_idx <= ptr[IDX_W-1:0];
          end else begin
            pend <= 1'b0;
          end
        end
        ACT_EXT_DONE: begin
          count      <= CNT_W'(count - 1'b1);
          res_status <= STATUS_OK;
          res_min    <= min_val;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((ctl.act == ACT_LOAD_OUT) && out_free) begin
      out_valid <= 1'b1;
      status    <= res_status;
      min_value <= res_min;
      occupancy <= OCC_W'(count);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ design/mpq_ram.sv @@
module mpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ tb/min_priority_queue_array_unit_test.sv @@
module min_priority_queue_array_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mpq_pkg::*;

  typedef struct {
    logic                     op;
    logic signed [DATA_W-1:0] val;
  } queue_word_t;

  typedef struct {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] min_value;
    logic [OCC_W-1:0]         occupancy;
  } queue_result_t;

  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 10;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     opcode = OP_INSERT;
  logic signed [DATA_W-1:0] insert_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] min_value;
  logic [OCC_W-1:0]         occupancy;

  queue_word_t   pending_words[$];
  queue_result_t awaited_results[$];

  logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
  int                       shadow_count = 0;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_req = 1'b0;
  int   hold_left = 0;
  int   errors = 0;

  min_priority_queue_array_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .insert_value (insert_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .min_value    (min_value),
    .occupancy    (occupancy)
  );

  always #5 clk = ~clk;

  function automatic queue_result_t apply_word(input logic op,
                                               input logic signed [DATA_W-1:0] val);
    queue_result_t r;
    int            pos;
    r = '{status: STATUS_OK, min_value: '0, occupancy: '0};
    if (op == OP_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        r.status = STATUS_OVERFLOW;
      end else begin
        shadow_entries[shadow_count] = val;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.status = STATUS_UNDERFLOW;
    end else begin
      pos = 0;
      for (int i = 1; i < shadow_count; i++) begin
        if (shadow_entries[i] < shadow_entries[pos]) pos = i;
      end
      r.min_value = shadow_entries[pos];
      for (int i = pos; i < shadow_count - 1; i++) begin
        shadow_entries[i] = shadow_entries[i + 1];
      end
      shadow_count--;
    end
    r.occupancy = OCC_W'(shadow_count);
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] draw_value();
    case ($urandom_range(3))
      0: return DATA_W'($urandom_range(8) - 4);
      1: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_word(input logic op, input logic signed [DATA_W-1:0] val);
    pending_words.push_back('{op: op, val: val});
  endtask

  task automatic queue_random(input int n, input int insert_pct);
    for (int i = 0; i < n; i++) begin
      queue_word(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_EXTRACT, draw_value());
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || awaited_results.size() != 0 || in_valid);
  endtask

  always @(posedge clk) begin : driver
    queue_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_results.push_back(apply_word(opcode, insert_value));
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          opcode <= w.op;
          insert_value <= w.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver_hold
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : monitor
    queue_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result word with nothing expected: status %0d min_value %0d occupancy %0d",
                 status, min_value, occupancy);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
          end
          if (min_value !== want.min_value) begin
            $error("min_value: expected %0d, got %0d", want.min_value, min_value);
            errors++;
          end
          if (occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
            errors++;
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    queue_word(OP_EXTRACT, 32'sh0000_1234);
    queue_word(OP_INSERT, 32'sh7fff_ffff);
    queue_word(OP_INSERT, 32'sh8000_0000);
    queue_word(OP_EXTRACT, '0);
    queue_word(OP_EXTRACT, '0);
    queue_word(OP_EXTRACT, '0);
    queue_word(OP_INSERT, 32'sd0);
    queue_word(OP_INSERT, -32'sd1);
    queue_word(OP_INSERT, 32'sd1);
    queue_word(OP_INSERT, 32'sd5);
    queue_word(OP_INSERT, 32'sd5);
    queue_word(OP_INSERT, -32'sd1);
    queue_word(OP_INSERT, 32'sd7);
    queue_word(OP_INSERT, 32'sh7fff_ffff);
    queue_word(OP_INSERT, 32'sd42);
    for (int i = 0; i < CAPACITY + 1; i++) queue_word(OP_EXTRACT, 32'shffff_ffff);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      if (phase == 0) begin
        hold_req = 1'b1;
        @(negedge clk);
        hold_req = 1'b0;
      end
      queue_random(50, 70);
      queue_random(50, 50);
      queue_random(50, 30);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("min_priority_queue_array_unit_test OK");
    end else begin
      $display("min_priority_queue_array_unit_test NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("min_priority_queue_array_unit_test NOT OK");
    $finish;
  end

endmodule
